// File: hdl/iqbf_pkg.sv
// shared types and constants for the island quantum best-fit select unit
// no dependencies
package iqbf_pkg;

    // configuration register indexes
    localparam logic CFG_MIN_QUANT = 1'b0;
    localparam logic CFG_IDLE_MULT = 1'b1;

    localparam int unsigned MIN_QUANT_RESET = 1000;
    localparam int MULT_BITS = 8;
    localparam int ID_BITS = 4;

    // status from a serial divider back to its controller
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: hdl/iqbf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on iqbf_pkg
module iqbf_div #(
    parameter int DW = 40,
    parameter int VW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [VW-1:0]     divisor,
    output iqbf_pkg::div_stat_t stat,
    output logic [DW-1:0]     quotient,
    output logic [VW-1:0]     remainder
);
    import iqbf_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] shift_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, shift_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = ~diff[VW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg  <= CW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            // quotient bits enter at the bottom as dividend bits leave the top
            shift_reg <= {shift_reg[DW-2:0], ge};
            rem_reg   <= ge ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/island_quantum_best_fit_select_unit.sv
// channel   direction  handshake            payload
// in        input      in_valid/in_stall    island descriptor, last_island ends a round
// out       output     out_valid/out_stall  one selection per round
// cfg       input      cfg_we               cfg_index, cfg_wdata
//
// each island passes through accept, load, the bit-serial divide of the extended
// quantum (COST_BITS + 8 steps) and update.
// the base and extended divides run side by side on two serial dividers.
// rst_n clears the running picks, the output register and sets register defaults.
// the result sits in an output register, so a stalled out does not block the
// next island; only a round end waits for the previous result to transfer.
// depends on iqbf_pkg and iqbf_div
module island_quantum_best_fit_select_unit #(
    parameter int MAX_ISLANDS = 16,
    parameter int COST_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [COST_BITS-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [iqbf_pkg::ID_BITS-1:0] island_id,
    input  logic                 kernel_fits,
    input  logic [COST_BITS-1:0] group_cost,
    input  logic                 needs_reconfig,
    input  logic [COST_BITS-1:0] reconfig_cost,
    input  logic                 last_island,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 found,
    output logic [iqbf_pkg::ID_BITS-1:0] chosen_island,
    output logic [39:0]          group_count,
    output logic [31:0]          chosen_group_cost,
    output logic [31:0]          chosen_reconfig_cost,
    output logic                 used_extended
);
    import iqbf_pkg::*;

    localparam int CB = COST_BITS;
    localparam int NW = COST_BITS + MULT_BITS;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_UPD} state_t;

    state_t state_reg;

    // configuration
    logic [CB-1:0]        min_quant_reg;
    logic [MULT_BITS-1:0] idle_mult_reg;

    // captured item
    logic [ID_BITS-1:0] id_reg;
    logic [CB-1:0]      g_reg;
    logic [CB-1:0]      r_reg;
    logic               last_reg;
    logic               elig_reg;
    logic [CB-1:0]      qb_reg;
    logic [NW-1:0]      qe_reg;
    logic               b_ok_reg;
    logic               e_ok_reg;

    // running picks
    logic               bv_reg;
    logic [ID_BITS-1:0] bi_reg;
    logic [CB-1:0]      bc_reg;
    logic [CB-1:0]      bg_reg;
    logic [CB-1:0]      br_reg;
    logic [CB-1:0]      bt_reg;
    logic               ev_reg;
    logic [ID_BITS-1:0] ei_reg;
    logic [NW-1:0]      ec_reg;
    logic [CB-1:0]      eg_reg;
    logic [CB-1:0]      er_reg;
    logic [NW-1:0]      et_reg;

    // output register
    logic               out_valid_reg;
    logic               found_reg;
    logic [ID_BITS-1:0] island_reg;
    logic [39:0]        count_reg;
    logic [31:0]        gcost_reg;
    logic [31:0]        rcost_reg;
    logic               ext_reg;

    logic               in_xfer;
    logic               out_xfer;
    logic               div_start;
    div_stat_t          b_stat;
    div_stat_t          e_stat;
    logic [CB-1:0]      b_quo;
    logic [CB-1:0]      b_rem;
    logic [NW-1:0]      e_quo;
    logic [CB-1:0]      e_rem;
    logic [CB-1:0]      b_dvd;
    logic [NW-1:0]      e_dvd;
    logic [CB-1:0]      tb;
    logic [NW-1:0]      te;
    logic               b_take;
    logic               e_take;
    logic               nbv;
    logic               nev;
    logic               use_ext;
    logic               can_finish;
    logic               emit;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign div_start = (state_reg == S_LOAD);

    assign b_dvd = qb_reg - r_reg;
    assign e_dvd = qe_reg - NW'(r_reg);

    iqbf_div #(.DW(CB), .VW(CB)) u_div_base (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (b_dvd),
        .divisor   (g_reg),
        .stat      (b_stat),
        .quotient  (b_quo),
        .remainder (b_rem)
    );

    iqbf_div #(.DW(NW), .VW(CB)) u_div_ext (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (e_dvd),
        .divisor   (g_reg),
        .stat      (e_stat),
        .quotient  (e_quo),
        .remainder (e_rem)
    );

    // total cost r + n*g equals quantum minus remainder
    assign tb = qb_reg - b_rem;
    assign te = qe_reg - NW'(e_rem);

    always_comb
    begin
        b_take = elig_reg && b_ok_reg && (b_quo != '0)
                 && (!bv_reg || (b_quo > bc_reg) || ((b_quo == bc_reg) && (tb < bt_reg)));
        e_take = elig_reg && e_ok_reg && (e_quo != '0)
                 && (!ev_reg || (e_quo > ec_reg) || ((e_quo == ec_reg) && (te < et_reg)));
        nbv     = bv_reg || b_take;
        nev     = ev_reg || e_take;
        use_ext = !nbv && (idle_mult_reg != '0) && nev;
        can_finish = !last_reg || !out_valid_reg || !out_stall;
        emit    = (state_reg == S_UPD) && can_finish && last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_quant_reg <= CB'(MIN_QUANT_RESET);
            idle_mult_reg <= '0;
            bv_reg        <= 1'b0;
            bi_reg        <= '0;
            bc_reg        <= '0;
            bg_reg        <= '0;
            br_reg        <= '0;
            bt_reg        <= '0;
            ev_reg        <= 1'b0;
            ei_reg        <= '0;
            ec_reg        <= '0;
            eg_reg        <= '0;
            er_reg        <= '0;
            et_reg        <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            island_reg    <= '0;
            count_reg     <= '0;
            gcost_reg     <= '0;
            rcost_reg     <= '0;
            ext_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_QUANT: min_quant_reg <= cfg_wdata;
                    CFG_IDLE_MULT: idle_mult_reg <= cfg_wdata[MULT_BITS-1:0];
                    default: ;
                endcase
            end

            if (out_xfer && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // extended divide is never shorter than the base one
                    if (e_stat.done && !b_stat.busy)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (can_finish)
                    begin
                        state_reg <= S_IDLE;
                        if (last_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            found_reg     <= nbv || use_ext;
                            ext_reg       <= use_ext;
                            if (nbv)
                            begin
                                island_reg <= b_take ? id_reg : bi_reg;
                                count_reg  <= 40'(b_take ? b_quo : bc_reg);
                                gcost_reg  <= 32'(b_take ? g_reg : bg_reg);
                                rcost_reg  <= 32'(b_take ? r_reg : br_reg);
                            end
                            else if (use_ext)
                            begin
                                island_reg <= e_take ? id_reg : ei_reg;
                                count_reg  <= 40'(e_take ? e_quo : ec_reg);
                                gcost_reg  <= 32'(e_take ? g_reg : eg_reg);
                                rcost_reg  <= 32'(e_take ? r_reg : er_reg);
                            end
                            else
                            begin
                                island_reg <= '0;
                                count_reg  <= '0;
                                gcost_reg  <= '0;
                                rcost_reg  <= '0;
                            end
                            // round over, start the next one empty
                            bv_reg <= 1'b0;
                            bi_reg <= '0;
                            bc_reg <= '0;
                            bg_reg <= '0;
                            br_reg <= '0;
                            bt_reg <= '0;
                            ev_reg <= 1'b0;
                            ei_reg <= '0;
                            ec_reg <= '0;
                            eg_reg <= '0;
                            er_reg <= '0;
                            et_reg <= '0;
                        end
                        else
                        begin
                            if (b_take)
                            begin
                                bv_reg <= 1'b1;
                                bi_reg <= id_reg;
                                bc_reg <= b_quo;
                                bg_reg <= g_reg;
                                br_reg <= r_reg;
                                bt_reg <= tb;
                            end
                            if (e_take)
                            begin
                                ev_reg <= 1'b1;
                                ei_reg <= id_reg;
                                ec_reg <= e_quo;
                                eg_reg <= g_reg;
                                er_reg <= r_reg;
                                et_reg <= te;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item capture and quantum setup, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            id_reg   <= island_id;
            g_reg    <= group_cost;
            r_reg    <= needs_reconfig ? reconfig_cost : '0;
            last_reg <= last_island;
            elig_reg <= kernel_fits && (group_cost != '0)
                        && (32'(island_id) < MAX_ISLANDS);
            qb_reg   <= min_quant_reg;
            qe_reg   <= NW'(min_quant_reg) * NW'(idle_mult_reg);
        end
        if (state_reg == S_LOAD)
        begin
            // reconfiguration must fit inside the quantum
            b_ok_reg <= (r_reg <= qb_reg);
            e_ok_reg <= (NW'(r_reg) <= qe_reg);
        end
    end

    assign out_valid            = out_valid_reg;
    assign found                = found_reg;
    assign chosen_island        = island_reg;
    assign group_count          = count_reg;
    assign chosen_group_cost    = gcost_reg;
    assign chosen_reconfig_cost = rcost_reg;
    assign used_extended        = ext_reg;

endmodule

// File: dv/island_quantum_best_fit_select_unit_tb.sv
// self-checking testbench for island_quantum_best_fit_select_unit: directed rounds, then random
// rounds under random idling on both channels, checked against an internal best-fit predictor
// depends on iqbf_pkg and the unit's rtl
module island_quantum_best_fit_select_unit_tb;
    import iqbf_pkg::*;

    localparam int COST_W        = 32;
    localparam int NUM_ISLANDS   = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1800;

    typedef struct {
        logic [ID_BITS-1:0] id;
        logic               fits;
        logic [COST_W-1:0]  gcost;
        logic               need;
        logic [COST_W-1:0]  rcost;
        logic               last;
    } island_desc_t;

    typedef struct {
        logic               valid;
        logic [ID_BITS-1:0] id;
        logic [39:0]        count;
        logic [31:0]        gcost;
        logic [31:0]        rcost;
        logic [39:0]        total;
    } fit_pick_t;

    typedef struct {
        logic               found;
        logic [ID_BITS-1:0] id;
        logic [39:0]        count;
        logic [31:0]        gcost;
        logic [31:0]        rcost;
        logic               ext;
    } selection_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = CFG_MIN_QUANT;
    logic [COST_W-1:0]    cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ID_BITS-1:0]   island_id = '0;
    logic                 kernel_fits = 1'b0;
    logic [COST_W-1:0]    group_cost = '0;
    logic                 needs_reconfig = 1'b0;
    logic [COST_W-1:0]    reconfig_cost = '0;
    logic                 last_island = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 found;
    logic [ID_BITS-1:0]   chosen_island;
    logic [39:0]          group_count;
    logic [31:0]          chosen_group_cost;
    logic [31:0]          chosen_reconfig_cost;
    logic                 used_extended;

    island_quantum_best_fit_select_unit dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .island_id            (island_id),
        .kernel_fits          (kernel_fits),
        .group_cost           (group_cost),
        .needs_reconfig       (needs_reconfig),
        .reconfig_cost        (reconfig_cost),
        .last_island          (last_island),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .found                (found),
        .chosen_island        (chosen_island),
        .group_count          (group_count),
        .chosen_group_cost    (chosen_group_cost),
        .chosen_reconfig_cost (chosen_reconfig_cost),
        .used_extended        (used_extended)
    );

    always #1 clk = ~clk;

    // predictor state and its copy of the registers
    logic [31:0]  pred_quant = MIN_QUANT_RESET;
    logic [7:0]   pred_mult = '0;
    fit_pick_t    base_best = '{default: '0};
    fit_pick_t    ext_best = '{default: '0};
    selection_t   due_selections[$];

    // stimulus side
    island_desc_t feed_q[$];
    logic [31:0]  stim_quant = MIN_QUANT_RESET;
    logic [7:0]   stim_mult = '0;
    logic [31:0]  prior_gcost = 32'd1;
    int           islands_queued = 0;
    int           islands_taken = 0;
    int           mismatches = 0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           idle_cycles = 0;
    logic         calm = 1'b0;    // no idling on either side
    logic         in_took = 1'b0;
    logic         out_took = 1'b0;

    function automatic fit_pick_t weigh_island(fit_pick_t best, logic [63:0] quant,
                                               logic [ID_BITS-1:0] id, logic [63:0] g,
                                               logic [63:0] r);
        logic [63:0] n;
        logic [63:0] t;
        if (r > quant)
            return best;
        n = (quant - r) / g;
        if (n == '0)
            return best;
        t = r + n * g;
        if (!best.valid || n > {24'b0, best.count}
            || (n == {24'b0, best.count} && t < {24'b0, best.total}))
        begin
            best.valid = 1'b1;
            best.id    = id;
            best.count = n[39:0];
            best.gcost = g[31:0];
            best.rcost = r[31:0];
            best.total = t[39:0];
        end
        return best;
    endfunction

    function automatic void track_island(island_desc_t d);
        logic [31:0] r;
        logic [63:0] ext_quant;
        selection_t  sel;
        r = d.need ? d.rcost : '0;
        ext_quant = {32'b0, pred_quant} * {56'b0, pred_mult};
        if (d.fits && d.gcost != 0 && d.id < NUM_ISLANDS)
        begin
            base_best = weigh_island(base_best, {32'b0, pred_quant}, d.id,
                                     {32'b0, d.gcost}, {32'b0, r});
            ext_best  = weigh_island(ext_best, ext_quant, d.id, {32'b0, d.gcost}, {32'b0, r});
        end
        if (!d.last)
            return;
        if (base_best.valid)
            sel = '{1'b1, base_best.id, base_best.count, base_best.gcost, base_best.rcost, 1'b0};
        else if (pred_mult != 0 && ext_best.valid)
            sel = '{1'b1, ext_best.id, ext_best.count, ext_best.gcost, ext_best.rcost, 1'b1};
        else
            sel = '{default: '0};
        due_selections.insert(due_selections.size(), sel);
        base_best = '{default: '0};
        ext_best  = '{default: '0};
    endfunction

    function automatic void check_field(string what, logic [39:0] want, logic [39:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // input side transfers and register writes feed the predictor
    always @(posedge clk)
    begin : in_monitor
        island_desc_t seen;
        in_took <= in_valid && !in_stall;
        if (rst_n && cfg_we)
        begin
            if (cfg_index == CFG_MIN_QUANT)
                pred_quant = cfg_wdata;
            else
                pred_mult = cfg_wdata[MULT_BITS-1:0];
        end
        if (rst_n && in_valid && !in_stall)
        begin
            seen = '{island_id, kernel_fits, group_cost, needs_reconfig, reconfig_cost,
                     last_island};
            track_island(seen);
            islands_taken++;
        end
    end

    always @(posedge clk)
    begin : out_monitor
        selection_t want;
        out_took <= out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_selections.size() == 0)
            begin
                $display("%0t: unexpected selection, expected none, actual island %0h found %b",
                         $time, chosen_island, found);
                mismatches++;
            end
            else
            begin
                want = due_selections[0];
                due_selections.delete(0);
                check_field("found", 40'(want.found), 40'(found));
                check_field("chosen_island", 40'(want.id), 40'(chosen_island));
                check_field("group_count", want.count, group_count);
                check_field("chosen_group_cost", 40'(want.gcost), 40'(chosen_group_cost));
                check_field("chosen_reconfig_cost", 40'(want.rcost),
                            40'(chosen_reconfig_cost));
                check_field("used_extended", 40'(want.ext), 40'(used_extended));
            end
        end
    end

    // sender: one island per transfer, random gap after each
    always @(negedge clk)
    begin : island_driver
        island_desc_t d;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (feed_q.size() != 0)
            begin
                d = feed_q[0];
                feed_q.delete(0);
                island_id      <= d.id;
                kernel_fits    <= d.fits;
                group_cost     <= d.gcost;
                needs_reconfig <= d.need;
                reconfig_cost  <= d.rcost;
                last_island    <= d.last;
                in_valid       <= 1'b1;
                send_gap       <= calm ? 0 : $urandom_range(0, 19);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: holds each presented selection for a random number of cycles
    always @(negedge clk)
    begin
        if (out_took)
            stall_left = calm ? 0 : $urandom_range(0, 19);
        else if (out_valid && stall_left > 0)
            stall_left = stall_left - 1;
        out_stall <= rst_n && stall_left > 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic feed_island(island_desc_t d);
        feed_q.insert(feed_q.size(), d);
        islands_queued++;
    endtask

    task automatic queue_island(logic [ID_BITS-1:0] id, logic fits, logic [31:0] g,
                                logic need, logic [31:0] r, logic last);
        island_desc_t d;
        d = '{id, fits, g, need, r, last};
        feed_island(d);
    endtask

    // all islands transferred, all selections in, and the last island has left the divider
    task automatic settle();
        do
            @(negedge clk);
        while (islands_taken != islands_queued || due_selections.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_QUANT)
            stim_quant = value;
        else
            stim_mult = value[7:0];
    endtask

    function automatic logic [31:0] draw_quant();
        case ($urandom_range(0, 7))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(1, 64);
            4, 5: return $urandom_range(100, 100000);
            default: return $urandom_range(1, 32'hFFFF_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] draw_mult();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // costs are mostly scaled to the quantum in force so that counts and ties stay interesting
    function automatic island_desc_t draw_island(logic last);
        island_desc_t d;
        logic [63:0]  reach;
        logic [31:0]  span;
        logic [31:0]  top;
        d.id   = $urandom_range(0, 15);
        d.fits = ($urandom_range(0, 9) != 0);
        d.need = $urandom_range(0, 1);
        d.last = last;
        if (stim_mult != 0 && $urandom_range(0, 2) == 0)
            reach = {32'b0, stim_quant} * {56'b0, stim_mult};
        else
            reach = {32'b0, stim_quant};
        span = (reach > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : reach[31:0];
        top = span / $urandom_range(1, 8);
        if (top == 0)
            top = 1;
        case ($urandom_range(0, 11))
            0: d.gcost = '0;
            1: d.gcost = $urandom();
            2: d.gcost = 32'hFFFF_FFFF;
            3, 4: d.gcost = prior_gcost;
            default: d.gcost = $urandom_range(1, top);
        endcase
        if (d.gcost != 0)
            prior_gcost = d.gcost;
        case ($urandom_range(0, 9))
            0: d.rcost = '0;
            1: d.rcost = $urandom();
            2: d.rcost = span;
            3: d.rcost = span + 1;
            default: d.rcost = $urandom_range(0, span / 2);
        endcase
        return d;
    endfunction

    initial
    begin : stimulus
        int rounds;
        int round_len;
        int split;
        int rand_fed;
        rand_fed = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset quantum 1000, no retry; equal count and total keeps the earlier island
        queue_island(4'd3, 1'b1, 32'd100, 1'b0, 32'd0, 1'b0);
        queue_island(4'd5, 1'b1, 32'd90, 1'b1, 32'd100, 1'b0);
        queue_island(4'd7, 1'b1, 32'd50, 1'b1, 32'd2000, 1'b0);    // reconfig past quantum
        queue_island(4'd9, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0);        // zero group cost
        queue_island(4'd11, 1'b0, 32'd1, 1'b0, 32'd0, 1'b0);       // kernel does not fit
        queue_island(4'd12, 1'b1, 32'd1001, 1'b0, 32'd0, 1'b0);    // no whole group fits
        queue_island(4'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b1);        // ineligible round end
        // equal count, later island has the lower total; unused reconfig cost ignored
        queue_island(4'd2, 1'b1, 32'd110, 1'b0, 32'hFFFF_FFFF, 1'b0);
        queue_island(4'd4, 1'b1, 32'd101, 1'b0, 32'd0, 1'b0);
        queue_island(4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        queue_island(4'd1, 1'b0, 32'd5, 1'b0, 32'd0, 1'b1);        // empty round
        queue_island(4'd6, 1'b1, 32'd10, 1'b1, 32'd1000, 1'b0);
        queue_island(4'd8, 1'b1, 32'd1, 1'b1, 32'd999, 1'b1);

        // base quantum finds nothing, retry quantum does
        write_reg(CFG_IDLE_MULT, 32'd5);
        write_reg(CFG_MIN_QUANT, 32'd10);
        queue_island(4'd10, 1'b1, 32'd20, 1'b0, 32'd0, 1'b0);
        queue_island(4'd13, 1'b1, 32'd25, 1'b1, 32'd0, 1'b1);
        // retry disabled in the middle of a round
        queue_island(4'd1, 1'b1, 32'd30, 1'b0, 32'd0, 1'b0);
        write_reg(CFG_IDLE_MULT, 32'd0);
        queue_island(4'd2, 1'b1, 32'd40, 1'b0, 32'd0, 1'b1);

        // widest quanta: retry counts reach the upper bits of group_count
        write_reg(CFG_MIN_QUANT, 32'hFFFF_FFFF);
        write_reg(CFG_IDLE_MULT, 32'd255);
        queue_island(4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
        queue_island(4'd0, 1'b1, 32'd1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        queue_island(4'd3, 1'b1, 32'd2, 1'b1, 32'hFFFF_FFFF, 1'b1);
        write_reg(CFG_MIN_QUANT, 32'd1);
        write_reg(CFG_IDLE_MULT, 32'd1);
        queue_island(4'd5, 1'b1, 32'd1, 1'b0, 32'd0, 1'b1);

        while (rand_fed < RANDOM_ITEMS)
        begin
            calm <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_MIN_QUANT, draw_quant());
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_IDLE_MULT, draw_mult());
            rounds = $urandom_range(3, 12);
            repeat (rounds)
            begin
                round_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                         : $urandom_range(1, 6);
                split = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 19) : 0;
                for (int k = 0; k < round_len; k++)
                begin
                    // register change with a round still open
                    if (k == split && k != 0)
                    begin
                        if ($urandom_range(0, 1) != 0)
                            write_reg(CFG_MIN_QUANT, draw_quant());
                        else
                            write_reg(CFG_IDLE_MULT, draw_mult());
                    end
                    feed_island(draw_island(k == round_len - 1));
                    rand_fed++;
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
